/* design/sli_pkg.sv */
// Shared types, codes and sizes for the sorted list store.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // Operation codes on the input word
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_DUMP   = 2'd2;

    // Status codes on the output word
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] entry;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } out_word_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                  op;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

/* design/sli_cell.sv */
// One slot of the sorted chain: holds a value and shifts with its neighbors.
module sli_cell (
    input  logic                               clk,
    input  sli_pkg::cell_ctl_t                 ctl,
    input  logic                               occ,
    input  logic signed [sli_pkg::VALUE_W-1:0] left_val,
    input  logic                               left_ge,
    input  logic signed [sli_pkg::VALUE_W-1:0] right_val,
    input  logic signed [sli_pkg::VALUE_W-1:0] head_val,
    input  logic                               wrap,
    input  logic                               hit_in,
    output logic signed [sli_pkg::VALUE_W-1:0] val,
    output logic                               ge,
    output logic                               hit_out
);

    logic signed [sli_pkg::VALUE_W-1:0] val_reg;
    logic signed [sli_pkg::VALUE_W-1:0] val_next;

    // Compare against the broadcast value; empty slots count as larger
    always_comb
    begin
        ge      = !occ || (val_reg >= ctl.value);
        hit_out = hit_in || (occ && (val_reg == ctl.value));
    end

    // Shift decision
    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.op)
            sli_pkg::CELL_HOLD:
            begin
                val_next = val_reg;
            end
            sli_pkg::CELL_INSERT:
            begin
                // first slot at or above the new value takes it, the rest move right
                if (ge)
                    val_next = left_ge ? left_val : ctl.value;
            end
            sli_pkg::CELL_DELETE:
            begin
                // slots from the first match on pull from the right
                if (hit_out)
                    val_next = right_val;
            end
            sli_pkg::CELL_ROTATE:
            begin
                // rotate left inside the occupied run
                val_next = wrap ? head_val : right_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* design/sorted_list_insert_delete.sv */
// Top level of the sorted list store: control, count and the chain of cells.
//
//   channel | signals                      | word
//   --------+------------------------------+-----------------------------------
//   in      | in_valid, in_ready, in_data  | func, value
//   out     | out_valid, out_ready, out_data | status, entry, count, last
//
// Insert and delete finish in the cycle they are accepted: every cell shifts at once.
// Their result word is valid from the next cycle.
// Dump enters its dump state on accept, then sends a word per stored entry, rotating
// the chain once per word and waiting on a stalled output; the chain is back in order
// after the last word. The next word is taken after that. An empty store answers EMPTY.
// One output register decouples the sides; a stalled output holds the chain.
// Reset clears the count and control; cell contents stay undefined until written.
module sorted_list_insert_delete (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sli_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sli_pkg::out_word_t out_data
);

    localparam int CAP = sli_pkg::CAPACITY;
    localparam int CW  = sli_pkg::COUNT_W;

    sli_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    sli_pkg::out_word_t out_data_reg, out_data_next;

    sli_pkg::cell_ctl_t ctl;
    logic               accept;
    logic               slot_free;
    logic               load;
    logic               full;
    logic               empty;
    logic               found;
    logic               dump_last;

    logic signed [sli_pkg::VALUE_W-1:0] cell_val [CAP];
    logic [CAP-1:0]     cell_ge;
    logic [CAP-1:0]     cell_hit;
    logic [CAP-1:0]     occ;

    // Occupancy from the count
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
            occ[i] = (fill_reg > CW'(i));
    end

    // Chain of cells
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic signed [sli_pkg::VALUE_W-1:0] lv;
        logic signed [sli_pkg::VALUE_W-1:0] rv;
        logic                               lg;
        logic                               hi;
        logic                               wr;

        if (i == 0)
        begin : g_first
            assign lv = cell_val[i];
            assign lg = 1'b0;
            assign hi = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cell_val[i-1];
            assign lg = cell_ge[i-1];
            assign hi = cell_hit[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign rv = cell_val[i];
            assign wr = 1'b1;
        end
        else
        begin : g_inner
            assign rv = cell_val[i+1];
            assign wr = !occ[i+1];
        end

        sli_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occ       (occ[i]),
            .left_val  (lv),
            .left_ge   (lg),
            .right_val (rv),
            .head_val  (cell_val[0]),
            .wrap      (wr),
            .hit_in    (hi),
            .val       (cell_val[i]),
            .ge        (cell_ge[i]),
            .hit_out   (cell_hit[i])
        );
    end

    // Handshake and status terms
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == sli_pkg::ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign full      = (fill_reg == CW'(CAP));
    assign empty     = (fill_reg == '0);
    assign found     = cell_hit[CAP-1];
    assign dump_last = (k_reg == fill_reg - CW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (accept && in_data.func == sli_pkg::FUNC_DUMP && !empty)
                    state_next = sli_pkg::ST_DUMP;
            end
            sli_pkg::ST_DUMP:
            begin
                if (slot_free && dump_last)
                    state_next = sli_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell command, count, result word
    always_comb
    begin
        ctl.op               = sli_pkg::CELL_HOLD;
        ctl.value            = in_data.value;
        fill_next            = fill_reg;
        k_next               = k_reg;
        load                 = 1'b0;
        out_data_next        = out_data_reg;
        out_data_next.status = sli_pkg::STAT_OK;
        out_data_next.entry  = '0;
        out_data_next.last   = 1'b1;

        unique case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.func)
                        sli_pkg::FUNC_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                                out_data_next.status = sli_pkg::STAT_FULL;
                            else
                            begin
                                ctl.op    = sli_pkg::CELL_INSERT;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        sli_pkg::FUNC_DELETE:
                        begin
                            load = 1'b1;
                            if (empty)
                                out_data_next.status = sli_pkg::STAT_EMPTY;
                            else if (!found)
                                out_data_next.status = sli_pkg::STAT_NOTFOUND;
                            else
                            begin
                                ctl.op    = sli_pkg::CELL_DELETE;
                                fill_next = fill_reg - CW'(1);
                            end
                        end
                        sli_pkg::FUNC_DUMP:
                        begin
                            k_next = '0;
                            if (empty)
                            begin
                                load                 = 1'b1;
                                out_data_next.status = sli_pkg::STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            sli_pkg::ST_DUMP:
            begin
                if (slot_free)
                begin
                    load                = 1'b1;
                    ctl.op              = sli_pkg::CELL_ROTATE;
                    out_data_next.entry = cell_val[0];
                    out_data_next.last  = dump_last;
                    k_next              = k_reg + CW'(1);
                end
            end
        endcase

        out_data_next.count = fill_next;
    end

    // Output valid
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sli_pkg::ST_IDLE;
            fill_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAP))
        else $error("count above capacity");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sli_pkg::ST_DUMP |-> (!empty && k_reg < fill_reg))
        else $error("dump index outside stored run");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.func == sli_pkg::FUNC_INSERT && !full)
        |=> fill_reg == $past(fill_reg) + CW'(1))
        else $error("insert did not raise the count");

    a_dump_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sli_pkg::ST_DUMP |=> $stable(fill_reg))
        else $error("count changed during dump");

endmodule
